// ===== design/can_rx_acceptance_filter_core_defines.svh =====
// Assertion macros used by the acceptance filter checker.
`ifndef CAN_RX_ACCEPTANCE_FILTER_CORE_DEFINES_SVH
`define CAN_RX_ACCEPTANCE_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CAF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acceptance filter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CAF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acceptance filter check failed");

`endif

// ===== design/caf_pkg.sv =====
// Types and constants of the CAN receive acceptance filter.
`default_nettype none

package caf_pkg;

    localparam int FILTER_ENTRIES = 32;
    localparam int IDX_W   = (FILTER_ENTRIES > 1) ? $clog2(FILTER_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(FILTER_ENTRIES + 1);
    localparam int ACT_W   = 6;
    localparam int EIDX_W  = 6;
    localparam int ID_W    = 11;
    localparam int WORD_W  = ID_W + 1;
    localparam int MATCH_W = 5;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 8;

    localparam logic MODE_CONFIG = 1'b0;
    localparam logic MODE_MATCH  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // The RTR bit of the mask is always set, so only the identifier part is stored.
    typedef struct packed {
        logic [ID_W-1:0]   mask;
        logic [WORD_W-1:0] ident;
    } entry_t;

    typedef struct packed {
        logic               deliver;
        logic [MATCH_W-1:0] match_index;
        logic               hit_found;
        logic               status;
    } result_t;

endpackage

`default_nettype wire

// ===== design/can_rx_acceptance_filter_core.sv =====
// Top level of the CAN receive acceptance filter: entry table and sequential search.
//
// Channel   Direction  Handshake                          Content
// s_axis    in         s_axis_tvalid / s_axis_tready      configure or match item
// m_axis    out        m_axis_tvalid / m_axis_tready      one result per item
// cfg       in         cfg_valid / cfg_ready              active entry count
//
// A configure item passes from the transfer through ST_DONE to the result register.
// A match item is scanned in ST_SCAN up to the first hit, entry k, or over all n entries
// without a hit, n being the active count capped at the table size, as the search reads
// one entry per cycle from the entry memory through its one read port.
// Reset clears the control state and the per-entry written flags at once; no sweep.
// A result waiting on m_axis does not block the next transfer on s_axis, but that
// item then stays in its final cycle until the waiting result has been taken.
`default_nettype none

module can_rx_acceptance_filter_core
    import caf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // entry_index, entry_id, entry_mask, entry_rtr, entry_has_handler, frame_id,
    // frame_rtr, zero padding
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // status, hit_found, match_index, deliver
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [ACT_W-1:0]      cfg_data
);

    // Input field unpacking.
    logic [EIDX_W-1:0] entry_index;
    logic [ID_W-1:0]   entry_id;
    logic [ID_W-1:0]   entry_mask;
    logic              entry_rtr;
    logic              entry_has_handler;
    logic [ID_W-1:0]   frame_id;
    logic              frame_rtr;

    assign entry_index       = s_axis_tdata[5:0];
    assign entry_id          = s_axis_tdata[16:6];
    assign entry_mask        = s_axis_tdata[27:17];
    assign entry_rtr         = s_axis_tdata[28];
    assign entry_has_handler = s_axis_tdata[29];
    assign frame_id          = s_axis_tdata[40:30];
    assign frame_rtr         = s_axis_tdata[41];

    state_t                    state_reg, state_next;
    logic [ACT_W-1:0]          active_reg;
    logic [CNT_W-1:0]          n_reg, n_next;
    logic [IDX_W-1:0]          count_reg, count_next;
    logic [WORD_W-1:0]         word_reg, word_next;
    result_t                   res_reg, res_next;
    logic                      out_valid_reg, out_valid_next;
    result_t                   out_res_reg, out_res_next;
    logic [FILTER_ENTRIES-1:0] written_reg, written_next;

    entry_t                    mem [FILTER_ENTRIES];
    entry_t                    rd_data_reg;
    logic                      rd_en;
    logic [IDX_W-1:0]          rd_addr;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    entry_t                    wr_data;

    logic [CNT_W-1:0]          n_cur;
    logic                      in_fire;
    logic                      legal;
    logic [WORD_W-1:0]         cur_ident;
    logic [WORD_W-1:0]         cur_mask;
    logic                      cur_hit;
    logic [CNT_W-1:0]          count_inc;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg;

    always_comb
    begin
        if (int'(active_reg) > FILTER_ENTRIES)
        begin
            n_cur = CNT_W'(FILTER_ENTRIES);
        end
        else
        begin
            n_cur = CNT_W'(active_reg);
        end
    end

    assign legal = entry_has_handler && (int'(entry_index) < int'(n_cur));

    // An entry never written is treated as identifier zero with a full mask.
    always_comb
    begin
        if (written_reg[count_reg])
        begin
            cur_ident = rd_data_reg.ident;
            cur_mask  = {1'b1, rd_data_reg.mask};
        end
        else
        begin
            cur_ident = '0;
            cur_mask  = '1;
        end
    end

    assign cur_hit   = (((word_reg ^ cur_ident) & cur_mask) == '0);
    assign count_inc = CNT_W'(count_reg) + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            written_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            written_reg   <= written_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        count_reg   <= count_next;
        word_reg    <= word_next;
        res_reg     <= res_next;
        out_res_reg <= out_res_next;
    end

    // Entry memory: one write and one read port, read data registered.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        count_next     = count_reg;
        word_next      = word_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        written_next   = written_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = IDX_W'(entry_index);
        wr_data        = '{mask: entry_mask, ident: {entry_rtr, entry_id}};

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_next = '0;
                    if (s_axis_tuser == MODE_CONFIG)
                    begin
                        if (legal)
                        begin
                            wr_en                 = 1'b1;
                            written_next[wr_addr] = 1'b1;
                        end
                        res_next.status = !legal;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        word_next = {frame_rtr, frame_id};
                        n_next    = n_cur;
                        if (n_cur == '0)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            count_next = '0;
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // rd_data_reg holds the entry at count_reg; fetch the next one while checking.
                if (cur_hit)
                begin
                    res_next.hit_found   = 1'b1;
                    res_next.match_index = MATCH_W'(count_reg);
                    res_next.deliver     = written_reg[count_reg];
                    state_next           = ST_DONE;
                end
                else if (count_inc == n_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(count_inc);
                    count_next = IDX_W'(count_inc);
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_res_next   = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/caf_checker.sv =====
// Port-level checker for the acceptance filter, bound to the top level.
`default_nettype none
`include "can_rx_acceptance_filter_core_defines.svh"

module caf_checker
    import caf_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // A stalled result keeps its value.
    `CAF_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // A configure status and a match hit never appear in the same result.
    `CAF_ASSERT_IMPL(a_status_xor_hit, clk, rst_n, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]))

    // Without a hit the index and delivery flag are zero.
    `CAF_ASSERT_IMPL(a_miss_clean, clk, rst_n, m_axis_tvalid && !m_axis_tdata[1], m_axis_tdata[7:2] == 6'd0)

    // Delivery requires a hit.
    `CAF_ASSERT_IMPL(a_deliver_hit, clk, rst_n, m_axis_tvalid && m_axis_tdata[7], m_axis_tdata[1])

endmodule

bind can_rx_acceptance_filter_core caf_checker u_caf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the CAN receive acceptance filter core.
module testbench;
    import caf_pkg::*;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int SETTLE_CYCLES   = FILTER_ENTRIES + 8;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 95;

    typedef struct {
        logic              mode;
        logic [EIDX_W-1:0] entry_index;
        logic [ID_W-1:0]   entry_id;
        logic [ID_W-1:0]   entry_mask;
        logic              entry_rtr;
        logic              entry_has_handler;
        logic [ID_W-1:0]   frame_id;
        logic              frame_rtr;
    } filter_item_t;

    class filter_scoreboard;
        int errors;
        logic [ACT_W-1:0]  active_count;
        logic [WORD_W-1:0] ident_table[FILTER_ENTRIES];
        logic [WORD_W-1:0] mask_table[FILTER_ENTRIES];
        logic              handler_table[FILTER_ENTRIES];
        result_t           awaited_results[$];

        function new();
            errors = 0;
            active_count = '0;
            for (int i = 0; i < FILTER_ENTRIES; i++)
            begin
                ident_table[i]   = '0;
                mask_table[i]    = '1;
                handler_table[i] = 1'b0;
            end
        endfunction

        // An active count beyond the table size searches the whole table.
        function int unsigned searched_entries();
            return (active_count > FILTER_ENTRIES) ? FILTER_ENTRIES : active_count;
        endfunction

        function void set_active(logic [ACT_W-1:0] value);
            active_count = value;
        endfunction

        function result_t predict_outcome(filter_item_t it);
            result_t           r;
            int unsigned       n;
            logic [WORD_W-1:0] word;
            logic              found;
            r = '0;
            found = 1'b0;
            n = searched_entries();
            if (it.mode == MODE_CONFIG)
            begin
                if (it.entry_has_handler && it.entry_index < n)
                begin
                    ident_table[it.entry_index]   = {it.entry_rtr, it.entry_id};
                    mask_table[it.entry_index]    = {1'b1, it.entry_mask};
                    handler_table[it.entry_index] = 1'b1;
                end
                else
                begin
                    r.status = 1'b1;
                end
            end
            else
            begin
                word = {it.frame_rtr, it.frame_id};
                for (int i = 0; i < n; i++)
                begin
                    if (!found && ((word ^ ident_table[i]) & mask_table[i]) == '0)
                    begin
                        found = 1'b1;
                        r.hit_found = 1'b1;
                        r.match_index = i[MATCH_W-1:0];
                        r.deliver = handler_table[i];
                    end
                end
            end
            return r;
        endfunction

        function void note_item(filter_item_t it);
            awaited_results.push_back(predict_outcome(it));
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [OUT_DATA_W-1:0] raw);
            result_t got;
            result_t want;
            got = result_t'(raw);
            if (awaited_results.size() == 0)
            begin
                report($sformatf("result %h arrived with nothing outstanding", raw));
                return;
            end
            want = awaited_results.pop_front();
            if (got.status != want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.hit_found != want.hit_found)
                report($sformatf("hit_found got %0d want %0d", got.hit_found, want.hit_found));
            if (got.match_index != want.match_index)
                report($sformatf("match_index got %0d want %0d",
                                 got.match_index, want.match_index));
            if (got.deliver != want.deliver)
                report($sformatf("deliver got %0d want %0d", got.deliver, want.deliver));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [ACT_W-1:0]      cfg_data = '0;

    logic              calm = 1'b0;
    int unsigned       cycle_count = 0;
    int unsigned       stall_left = 0;
    filter_scoreboard  sb;

    can_rx_acceptance_filter_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver side: random back-pressure, held off entirely during calm phases.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < 25)
        begin
            stall_left = pick_gap();
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // tdata from the lowest bit: entry_index, entry_id, entry_mask, entry_rtr,
    // entry_has_handler, frame_id, frame_rtr, zero padding.
    function automatic logic [IN_DATA_W-1:0] pack_item(filter_item_t it);
        return {6'b0, it.frame_rtr, it.frame_id, it.entry_has_handler, it.entry_rtr,
                it.entry_mask, it.entry_id, it.entry_index};
    endfunction

    task automatic send_item(filter_item_t it);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_item(it);
        s_axis_tuser  <= it.mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_item(it);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_fields(logic mode, int unsigned idx, int unsigned id,
                               int unsigned mask, logic rtr, logic handler,
                               int unsigned fid, logic frtr);
        filter_item_t it;
        it.mode              = mode;
        it.entry_index       = EIDX_W'(idx);
        it.entry_id          = ID_W'(id);
        it.entry_mask        = ID_W'(mask);
        it.entry_rtr         = rtr;
        it.entry_has_handler = handler;
        it.frame_id          = ID_W'(fid);
        it.frame_rtr         = frtr;
        send_item(it);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_active(int unsigned value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= ACT_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_active(ACT_W'(value));
        cfg_valid <= 1'b0;
    endtask

    // Mostly legal writes and frames aimed at stored entries, the rest unshaped.
    function automatic filter_item_t random_item();
        filter_item_t      it;
        int unsigned       n;
        int unsigned       pick;
        int unsigned       j;
        logic [WORD_W-1:0] word;
        n = sb.searched_entries();
        it.mode              = 1'($urandom_range(0, 1));
        it.entry_index       = EIDX_W'($urandom);
        it.entry_id          = ID_W'($urandom);
        it.entry_mask        = ID_W'($urandom);
        it.entry_rtr         = 1'($urandom_range(0, 1));
        it.entry_has_handler = 1'($urandom_range(0, 1));
        it.frame_id          = ID_W'($urandom);
        it.frame_rtr         = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            it.mode = MODE_CONFIG;
            it.entry_has_handler = 1'b1;
            if (n > 0)
                it.entry_index = EIDX_W'($urandom_range(0, n - 1));
            case ($urandom_range(0, 3))
                0: it.entry_mask = '1;
                1: it.entry_mask = ID_W'($urandom | $urandom);
                2: it.entry_mask = ID_W'($urandom & $urandom & $urandom);
                default: ;
            endcase
        end
        else if (pick < 85)
        begin
            it.mode = MODE_MATCH;
            if (n > 0 && $urandom_range(0, 4) != 0)
            begin
                j = $urandom_range(0, n - 1);
                word = sb.ident_table[j] ^ (WORD_W'($urandom) & ~sb.mask_table[j]);
                if ($urandom_range(0, 9) == 0)
                    word = word ^ (WORD_W'(1) << $urandom_range(0, WORD_W - 1));
                {it.frame_rtr, it.frame_id} = word;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                it.frame_id  = '0;
                it.frame_rtr = 1'b0;
            end
        end
        return it;
    endfunction

    initial
    begin
        int unsigned value;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_active(4);
        send_fields(MODE_CONFIG, 0, 'h7FF, 'h7FF, 1'b1, 1'b1, 0, 1'b0);
        send_fields(MODE_CONFIG, 3, 0, 0, 1'b0, 1'b0, 0, 1'b0);
        send_fields(MODE_CONFIG, 4, 'h100, 'h7FF, 1'b0, 1'b1, 0, 1'b0);
        send_fields(MODE_CONFIG, 63, 'h100, 'h7FF, 1'b0, 1'b1, 0, 1'b0);
        send_fields(MODE_CONFIG, 2, 'h123, 'h700, 1'b0, 1'b1, 0, 1'b0);
        send_fields(MODE_MATCH, 0, 0, 0, 1'b0, 1'b0, 'h7FF, 1'b1);
        send_fields(MODE_MATCH, 0, 0, 0, 1'b0, 1'b0, 'h7FF, 1'b0);
        // Identifier zero data frame is caught by an entry that was never written.
        send_fields(MODE_MATCH, 0, 0, 0, 1'b0, 1'b0, 0, 1'b0);
        send_fields(MODE_MATCH, 63, 'h7FF, 'h7FF, 1'b1, 1'b1, 'h1FF, 1'b0);
        send_fields(MODE_MATCH, 0, 0, 0, 1'b0, 1'b0, 0, 1'b1);

        write_active(63);
        send_fields(MODE_CONFIG, 31, 'h555, 'h7FF, 1'b0, 1'b1, 0, 1'b0);
        send_fields(MODE_CONFIG, 32, 'h555, 'h7FF, 1'b0, 1'b1, 0, 1'b0);
        send_fields(MODE_MATCH, 0, 0, 0, 1'b0, 1'b0, 'h555, 1'b0);
        send_fields(MODE_CONFIG, 1, 0, 0, 1'b1, 1'b1, 0, 1'b0);
        send_fields(MODE_MATCH, 0, 0, 0, 1'b0, 1'b0, 'h2AA, 1'b1);

        write_active(0);
        send_fields(MODE_CONFIG, 0, 'h7FF, 'h7FF, 1'b1, 1'b1, 0, 1'b0);
        send_fields(MODE_MATCH, 0, 0, 0, 1'b0, 1'b0, 0, 1'b0);

        write_active(32);
        send_fields(MODE_MATCH, 0, 0, 0, 1'b0, 1'b0, 0, 1'b0);
        send_fields(MODE_MATCH, 0, 0, 0, 1'b0, 1'b0, 'h555, 1'b0);

        write_active(1);
        send_fields(MODE_MATCH, 0, 0, 0, 1'b0, 1'b0, 'h7FF, 1'b1);
        send_fields(MODE_CONFIG, 0, 0, 0, 1'b0, 1'b1, 0, 1'b0);
        send_fields(MODE_MATCH, 0, 0, 0, 1'b0, 1'b0, 'h3C3, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: value = 32;
                1: value = 63;
                2: value = 0;
                3: value = 1;
                4: value = 31;
                default: value = $urandom_range(0, 63);
            endcase
            calm = (p % 3 == 2);
            write_active(value);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (p == 1 && k == 50)
                    drain_results();
                send_item(random_item());
            end
        end

        drain_results();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
